/* hw/rtl/lbc_pkg.sv */
// ----------------------------------------------------------------------------
// lbc_pkg: shared definitions of the LED blink controller
// Field widths, command and action codes, mode bit positions, register
// indexes, reset values and the words passed between pipeline stages.
// ----------------------------------------------------------------------------
package lbc_pkg;

	localparam int NUM_LEDS    = 4;
	localparam int OP_W        = 3;
	localparam int SMODE_W     = 3;
	localparam int COUNT_W     = 8;
	localparam int PCT_W       = 8;
	localparam int DUTY_W      = 7;
	localparam int PERIOD_W    = 16;
	localparam int WAIT_W      = 16;
	localparam int MODE_W      = 3;
	localparam int PROD_W      = DUTY_W + PERIOD_W;
	localparam int RECIP_W     = 24;
	localparam int FULL_W      = PROD_W + RECIP_W;
	localparam int RECIP_SHIFT = 30;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	// ceil(2^30 / 100): exact quotient for every product below 2^23
	localparam logic [RECIP_W-1:0]  RECIP_100 = 24'd10737419;
	localparam logic [PCT_W-1:0]    PCT_FULL  = 8'd100;
	localparam logic [DUTY_W-1:0]   DUTY_FULL = 7'd100;

	localparam logic [COUNT_W-1:0]  RST_FLASH_COUNT = 8'd4;
	localparam logic [DUTY_W-1:0]   RST_DUTY        = 7'd50;
	localparam logic [PERIOD_W-1:0] RST_PERIOD      = 16'd1000;

	// mode bit positions
	localparam int MB_ON    = 0;
	localparam int MB_BLINK = 1;
	localparam int MB_FLASH = 2;

	typedef logic [NUM_LEDS-1:0] led_vec_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FLASH_COUNT = 2'd0,
		CFG_DUTY        = 2'd1,
		CFG_PERIOD      = 2'd2
	} cfg_idx_t;

	typedef enum logic [OP_W-1:0] {
		OP_TICK  = 3'd0,
		OP_SET   = 3'd1,
		OP_BLINK = 3'd2,
		OP_SLEEP = 3'd3,
		OP_WAKE  = 3'd4
	} op_t;

	typedef enum logic [SMODE_W-1:0] {
		SM_OFF    = 3'd0,
		SM_ON     = 3'd1,
		SM_TOGGLE = 3'd2,
		SM_ONCE   = 3'd3,
		SM_FLASH  = 3'd4
	} smode_t;

	typedef enum logic [2:0] {
		ACT_NONE   = 3'd0,
		ACT_OFF    = 3'd1,
		ACT_ON     = 3'd2,
		ACT_TOGGLE = 3'd3,
		ACT_BLINK  = 3'd4,
		ACT_TICK   = 3'd5,
		ACT_SLEEP  = 3'd6,
		ACT_WAKE   = 3'd7
	} act_t;

	typedef struct packed {
		logic [OP_W-1:0]     op;
		led_vec_t            mask;
		logic [SMODE_W-1:0]  smode;
		logic [COUNT_W-1:0]  count;
		logic [PCT_W-1:0]    pct;
		logic [PERIOD_W-1:0] period;
	} cmd_t;

	typedef struct packed {
		act_t                act;
		logic                upd;
		led_vec_t            mask;
		logic [COUNT_W-1:0]  count;
		logic [PROD_W-1:0]   on_prod;
		logic [PROD_W-1:0]   off_prod;
	} dec_t;

	typedef struct packed {
		act_t                act;
		logic                upd;
		led_vec_t            mask;
		logic [COUNT_W-1:0]  count;
		logic [WAIT_W-1:0]   on_wait;
		logic [WAIT_W-1:0]   off_wait;
	} scl_t;

endpackage

/* hw/rtl/lbc_if.sv */
// ----------------------------------------------------------------------------
// lbc_if: command and response channels of the LED blink controller
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface lbc_in_if;
	logic                         valid;
	logic                         ready;
	logic [lbc_pkg::OP_W-1:0]     op;
	logic [lbc_pkg::NUM_LEDS-1:0] led_mask;
	logic [lbc_pkg::SMODE_W-1:0]  set_mode;
	logic [lbc_pkg::COUNT_W-1:0]  blink_count;
	logic [lbc_pkg::PCT_W-1:0]    on_percent;
	logic [lbc_pkg::PERIOD_W-1:0] period_ms;

	modport source (
		output valid, op, led_mask, set_mode, blink_count, on_percent, period_ms,
		input  ready
	);
	modport sink (
		input  valid, op, led_mask, set_mode, blink_count, on_percent, period_ms,
		output ready
	);
endinterface

interface lbc_out_if;
	logic                         valid;
	logic                         ready;
	logic [lbc_pkg::NUM_LEDS-1:0] led_state;
	logic [lbc_pkg::WAIT_W-1:0]   next_wait_ms;

	modport source (
		output valid, led_state, next_wait_ms,
		input  ready
	);
	modport sink (
		input  valid, led_state, next_wait_ms,
		output ready
	);
endinterface

/* hw/rtl/led_blink_controller_top.sv */
// ----------------------------------------------------------------------------
// led_blink_controller_top: four-LED blink engine
// Command in, LED state and shortest pending wait out, one word per command.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one command word: a 1 ms tick, a set command on an LED mask,
//   a blink command (count, on percent, period), sleep entry or sleep exit.
//   rsp returns one word per command: the LED on states and the shortest
//   nonzero countdown left after the update step (zero if none or asleep).
//   cfg_wr_en / cfg_index / cfg_data write the flash count (index 0), the
//   default on percent (1) and the default period in ms (2); write them only
//   while no command is in flight.
//   Throughput: one command per cycle while rsp is taken; the four stages are
//   command register, share product, divide by 100, then LED update with result register.
//   Reset: all LEDs off and idle, awake, defaults 4 / 50 % / 1000 ms.
//   Stall: when rsp is not taken the pipeline fills its bubbles and holds up
//   to four words; cmd.ready then drops until the result is taken.
// ----------------------------------------------------------------------------
module led_blink_controller_top (
	input  logic                           clk,
	input  logic                           arst_n,
	lbc_in_if.sink                         cmd,
	lbc_out_if.source                      rsp,
	input  logic                           cfg_wr_en,
	input  logic [lbc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lbc_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic          dec_valid;
	logic          dec_ready;
	lbc_pkg::dec_t dec;
	logic          scl_valid;
	logic          scl_ready;
	lbc_pkg::scl_t scl;

	lbc_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.dec_valid (dec_valid),
		.dec_ready (dec_ready),
		.dec       (dec)
	);

	lbc_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.dec_valid (dec_valid),
		.dec_ready (dec_ready),
		.dec       (dec),
		.scl_valid (scl_valid),
		.scl_ready (scl_ready),
		.scl       (scl)
	);

	lbc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.scl_valid (scl_valid),
		.scl_ready (scl_ready),
		.scl       (scl),
		.rsp       (rsp)
	);

endmodule

/* hw/rtl/lbc_decode.sv */
// ----------------------------------------------------------------------------
// lbc_decode: command register, decode and share products
// Holds the default registers, registers the incoming command, turns it into
// an LED action and forms on share x period and off share x period.
// ----------------------------------------------------------------------------
module lbc_decode (
	input  logic                             clk,
	input  logic                             arst_n,
	lbc_in_if.sink                           cmd,
	input  logic                             cfg_wr_en,
	input  logic [lbc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lbc_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                             dec_valid,
	input  logic                             dec_ready,
	output lbc_pkg::dec_t                    dec
);

	logic [lbc_pkg::COUNT_W-1:0]  flash_q;
	logic [lbc_pkg::DUTY_W-1:0]   duty_q;
	logic [lbc_pkg::PERIOD_W-1:0] period_q;

	logic          valid_s1;
	lbc_pkg::cmd_t cmd_s1;
	logic          valid_s2;
	lbc_pkg::dec_t dec_s2;
	logic          s1_ready;
	logic          s2_ready;

	lbc_pkg::act_t                act;
	logic                         upd;
	logic                         blink_like;
	logic [lbc_pkg::COUNT_W-1:0]  b_count;
	logic [lbc_pkg::PCT_W-1:0]    b_pct;
	logic [lbc_pkg::PERIOD_W-1:0] b_period;
	logic [lbc_pkg::DUTY_W-1:0]   duty7;
	logic [lbc_pkg::PROD_W-1:0]   on_prod;
	logic [lbc_pkg::PROD_W-1:0]   off_prod;

	assign s2_ready  = !valid_s2 || dec_ready;
	assign s1_ready  = !valid_s1 || s2_ready;
	assign cmd.ready = s1_ready;
	assign dec_valid = valid_s2;
	assign dec       = dec_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flash_q  <= lbc_pkg::RST_FLASH_COUNT;
			duty_q   <= lbc_pkg::RST_DUTY;
			period_q <= lbc_pkg::RST_PERIOD;
		end else if (cfg_wr_en) begin
			unique case (lbc_pkg::cfg_idx_t'(cfg_index))
				lbc_pkg::CFG_FLASH_COUNT: flash_q  <= cfg_data[lbc_pkg::COUNT_W-1:0];
				lbc_pkg::CFG_DUTY:        duty_q   <= cfg_data[lbc_pkg::DUTY_W-1:0];
				lbc_pkg::CFG_PERIOD:      period_q <= cfg_data[lbc_pkg::PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_ready) begin
				valid_s1 <= cmd.valid;
			end
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && s1_ready) begin
			cmd_s1.op     <= cmd.op;
			cmd_s1.mask   <= cmd.led_mask;
			cmd_s1.smode  <= cmd.set_mode;
			cmd_s1.count  <= cmd.blink_count;
			cmd_s1.pct    <= cmd.on_percent;
			cmd_s1.period <= cmd.period_ms;
		end
		if (valid_s1 && s2_ready) begin
			dec_s2.act      <= act;
			dec_s2.upd      <= upd;
			dec_s2.mask     <= cmd_s1.mask;
			dec_s2.count    <= b_count;
			dec_s2.on_prod  <= on_prod;
			dec_s2.off_prod <= off_prod;
		end
	end

	always_comb begin
		act        = lbc_pkg::ACT_NONE;
		upd        = 1'b0;
		blink_like = 1'b0;
		b_count    = cmd_s1.count;
		b_pct      = cmd_s1.pct;
		b_period   = cmd_s1.period;
		unique case (lbc_pkg::op_t'(cmd_s1.op))
			lbc_pkg::OP_TICK: begin
				act = lbc_pkg::ACT_TICK;
				upd = 1'b1;
			end
			lbc_pkg::OP_SET: begin
				upd = 1'b1;
				unique case (lbc_pkg::smode_t'(cmd_s1.smode))
					lbc_pkg::SM_OFF:    act = lbc_pkg::ACT_OFF;
					lbc_pkg::SM_ON:     act = lbc_pkg::ACT_ON;
					lbc_pkg::SM_TOGGLE: act = lbc_pkg::ACT_TOGGLE;
					lbc_pkg::SM_ONCE: begin
						blink_like = 1'b1;
						b_count    = lbc_pkg::COUNT_W'(1);
						b_pct      = {1'b0, duty_q};
						b_period   = period_q;
					end
					lbc_pkg::SM_FLASH: begin
						blink_like = 1'b1;
						b_count    = flash_q;
						b_pct      = {1'b0, duty_q};
						b_period   = period_q;
					end
					default: act = lbc_pkg::ACT_NONE;
				endcase
			end
			lbc_pkg::OP_BLINK: begin
				blink_like = 1'b1;
				upd        = 1'b1;
			end
			lbc_pkg::OP_SLEEP: act = lbc_pkg::ACT_SLEEP;
			lbc_pkg::OP_WAKE:  act = lbc_pkg::ACT_WAKE;
			default:           act = lbc_pkg::ACT_NONE;
		endcase

		// empty mask, zero share or zero period drop to plain off; a share of 100 or more to plain on
		if (blink_like) begin
			if (cmd_s1.mask == '0 || b_pct == '0 || b_period == '0) begin
				act = lbc_pkg::ACT_OFF;
			end else if (b_pct >= lbc_pkg::PCT_FULL) begin
				act = lbc_pkg::ACT_ON;
			end else begin
				act = lbc_pkg::ACT_BLINK;
			end
		end
	end

	assign duty7    = b_pct[lbc_pkg::DUTY_W-1:0];
	assign on_prod  = lbc_pkg::PROD_W'(duty7) * lbc_pkg::PROD_W'(b_period);
	assign off_prod = lbc_pkg::PROD_W'(lbc_pkg::DUTY_FULL - duty7)
	                  * lbc_pkg::PROD_W'(b_period);

endmodule

/* hw/rtl/lbc_scale.sv */
// ----------------------------------------------------------------------------
// lbc_scale: divide the share products by 100
// Multiplies each product by a scaled reciprocal of 100 and registers the
// on and off reload values.
// ----------------------------------------------------------------------------
module lbc_scale (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          dec_valid,
	output logic          dec_ready,
	input  lbc_pkg::dec_t dec,
	output logic          scl_valid,
	input  logic          scl_ready,
	output lbc_pkg::scl_t scl
);

	logic          valid_s3;
	lbc_pkg::scl_t scl_s3;
	logic [lbc_pkg::FULL_W-1:0] on_full;
	logic [lbc_pkg::FULL_W-1:0] off_full;

	assign dec_ready = !valid_s3 || scl_ready;
	assign scl_valid = valid_s3;
	assign scl       = scl_s3;

	assign on_full  = lbc_pkg::FULL_W'(dec.on_prod)  * lbc_pkg::FULL_W'(lbc_pkg::RECIP_100);
	assign off_full = lbc_pkg::FULL_W'(dec.off_prod) * lbc_pkg::FULL_W'(lbc_pkg::RECIP_100);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (dec_ready) begin
			valid_s3 <= dec_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (dec_valid && dec_ready) begin
			scl_s3.act      <= dec.act;
			scl_s3.upd      <= dec.upd;
			scl_s3.mask     <= dec.mask;
			scl_s3.count    <= dec.count;
			scl_s3.on_wait  <= on_full[lbc_pkg::RECIP_SHIFT +: lbc_pkg::WAIT_W];
			scl_s3.off_wait <= off_full[lbc_pkg::RECIP_SHIFT +: lbc_pkg::WAIT_W];
		end
	end

endmodule

/* hw/rtl/lbc_core.sv */
// ----------------------------------------------------------------------------
// lbc_core: per-LED blink state and result register
// Applies the action to each LED lane, runs the update step, finds the
// shortest pending wait and registers the response word.
// ----------------------------------------------------------------------------
module lbc_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          scl_valid,
	output logic          scl_ready,
	input  lbc_pkg::scl_t scl,
	lbc_out_if.source     rsp
);

	logic [lbc_pkg::MODE_W-1:0]  mode_q     [lbc_pkg::NUM_LEDS];
	logic [lbc_pkg::COUNT_W-1:0] blinks_q   [lbc_pkg::NUM_LEDS];
	logic [lbc_pkg::WAIT_W-1:0]  on_wait_q  [lbc_pkg::NUM_LEDS];
	logic [lbc_pkg::WAIT_W-1:0]  off_wait_q [lbc_pkg::NUM_LEDS];
	logic [lbc_pkg::WAIT_W-1:0]  cd_q       [lbc_pkg::NUM_LEDS];
	lbc_pkg::led_vec_t           lit_q;
	lbc_pkg::led_vec_t           saved_q;
	logic                        asleep_q;

	logic [lbc_pkg::MODE_W-1:0]  mode_nxt     [lbc_pkg::NUM_LEDS];
	logic [lbc_pkg::COUNT_W-1:0] blinks_nxt   [lbc_pkg::NUM_LEDS];
	logic [lbc_pkg::WAIT_W-1:0]  on_wait_nxt  [lbc_pkg::NUM_LEDS];
	logic [lbc_pkg::WAIT_W-1:0]  off_wait_nxt [lbc_pkg::NUM_LEDS];
	logic [lbc_pkg::WAIT_W-1:0]  cd_nxt       [lbc_pkg::NUM_LEDS];
	logic [lbc_pkg::WAIT_W-1:0]  wait_v       [lbc_pkg::NUM_LEDS];
	lbc_pkg::led_vec_t           lit_nxt;
	logic [lbc_pkg::WAIT_W-1:0]  next_min;

	logic                        out_valid_q;
	lbc_pkg::led_vec_t           led_state_q;
	logic [lbc_pkg::WAIT_W-1:0]  next_wait_q;
	logic                        fire;
	lbc_pkg::led_vec_t           blink_vec;

	assign scl_ready        = !out_valid_q || rsp.ready;
	assign fire             = scl_valid && scl_ready;
	assign rsp.valid        = out_valid_q;
	assign rsp.led_state    = led_state_q;
	assign rsp.next_wait_ms = next_wait_q;

	always_comb begin
		logic [lbc_pkg::MODE_W-1:0]  m;
		logic [lbc_pkg::COUNT_W-1:0] bl;
		logic [lbc_pkg::WAIT_W-1:0]  cd;
		logic [lbc_pkg::WAIT_W-1:0]  onw;
		logic [lbc_pkg::WAIT_W-1:0]  offw;
		logic [lbc_pkg::WAIT_W-1:0]  wt;
		logic                        lit;
		logic                        run;

		run     = scl.upd && !asleep_q;
		lit_nxt = lit_q;
		for (int i = 0; i < lbc_pkg::NUM_LEDS; i++) begin
			m    = mode_q[i];
			bl   = blinks_q[i];
			cd   = cd_q[i];
			onw  = on_wait_q[i];
			offw = off_wait_q[i];
			lit  = lit_q[i];
			wt   = '0;

			unique case (scl.act)
				lbc_pkg::ACT_NONE: ;
				lbc_pkg::ACT_TICK: begin
					if (!asleep_q && m[lbc_pkg::MB_BLINK] && cd != '0) begin
						cd = cd - lbc_pkg::WAIT_W'(1);
					end
				end
				lbc_pkg::ACT_OFF: begin
					if (scl.mask[i]) begin
						m   = '0;
						lit = 1'b0;
					end
				end
				lbc_pkg::ACT_ON: begin
					if (scl.mask[i]) begin
						m                = '0;
						m[lbc_pkg::MB_ON] = 1'b1;
						lit              = 1'b1;
					end
				end
				lbc_pkg::ACT_TOGGLE: begin
					// flip the on bit only, so a blinking lane keeps blinking
					if (scl.mask[i]) begin
						m[lbc_pkg::MB_ON] = !m[lbc_pkg::MB_ON];
						lit               = m[lbc_pkg::MB_ON];
					end
				end
				lbc_pkg::ACT_BLINK: begin
					if (scl.mask[i]) begin
						m                    = '0;
						m[lbc_pkg::MB_BLINK] = 1'b1;
						m[lbc_pkg::MB_FLASH] = (scl.count == '0);
						bl                   = scl.count;
						onw                  = scl.on_wait;
						offw                 = scl.off_wait;
						cd                   = '0;
					end
				end
				lbc_pkg::ACT_SLEEP: lit = 1'b0;
				lbc_pkg::ACT_WAKE:  lit = lit | saved_q[i];
			endcase

			// update step: an expired countdown flips the lane and reloads, or ends the blink once the count is used up
			if (run && m[lbc_pkg::MB_BLINK]) begin
				if (cd == '0) begin
					if (m[lbc_pkg::MB_ON]) begin
						m[lbc_pkg::MB_ON] = 1'b0;
						lit               = 1'b0;
						if (!m[lbc_pkg::MB_FLASH]) begin
							bl = bl - lbc_pkg::COUNT_W'(1);
						end
						cd = offw;
						wt = offw;
					end else if (bl == '0 && !m[lbc_pkg::MB_FLASH]) begin
						m[lbc_pkg::MB_BLINK] = 1'b0;
					end else begin
						m[lbc_pkg::MB_ON] = 1'b1;
						lit               = 1'b1;
						cd                = onw;
						wt                = onw;
					end
				end else begin
					wt = cd;
				end
			end

			mode_nxt[i]     = m;
			blinks_nxt[i]   = bl;
			cd_nxt[i]       = cd;
			on_wait_nxt[i]  = onw;
			off_wait_nxt[i] = offw;
			lit_nxt[i]      = lit;
			wait_v[i]       = wt;
		end
	end

	// shortest nonzero wait; idle lanes carry zero and never win
	always_comb begin
		next_min = '0;
		for (int i = 0; i < lbc_pkg::NUM_LEDS; i++) begin
			if (next_min == '0 || (wait_v[i] != '0 && wait_v[i] < next_min)) begin
				next_min = wait_v[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lbc_pkg::NUM_LEDS; i++) begin
				mode_q[i]     <= '0;
				blinks_q[i]   <= '0;
				on_wait_q[i]  <= '0;
				off_wait_q[i] <= '0;
				cd_q[i]       <= '0;
			end
			lit_q    <= '0;
			saved_q  <= '0;
			asleep_q <= 1'b0;
		end else if (fire) begin
			for (int i = 0; i < lbc_pkg::NUM_LEDS; i++) begin
				mode_q[i]     <= mode_nxt[i];
				blinks_q[i]   <= blinks_nxt[i];
				on_wait_q[i]  <= on_wait_nxt[i];
				off_wait_q[i] <= off_wait_nxt[i];
				cd_q[i]       <= cd_nxt[i];
			end
			lit_q <= lit_nxt;
			if (scl.act == lbc_pkg::ACT_SLEEP) begin
				saved_q  <= lit_q;
				asleep_q <= 1'b1;
			end else if (scl.act == lbc_pkg::ACT_WAKE) begin
				asleep_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (scl_ready) begin
			out_valid_q <= scl_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			led_state_q <= lit_nxt;
			next_wait_q <= next_min;
		end
	end

	always_comb begin
		for (int i = 0; i < lbc_pkg::NUM_LEDS; i++) begin
			blink_vec[i] = mode_q[i][lbc_pkg::MB_BLINK];
		end
	end

	a_sleep_no_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && asleep_q) |=> (next_wait_q == '0))
		else $error("pending wait reported while asleep");

	a_sleep_dark: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && scl.act == lbc_pkg::ACT_SLEEP) |=> (lit_q == '0 && asleep_q))
		else $error("sleep entry left an LED lit or the block awake");

	a_wake: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && scl.act == lbc_pkg::ACT_WAKE) |=> (!asleep_q && ((lit_q & $past(saved_q)) == $past(saved_q))))
		else $error("wake did not restore the saved LEDs");

	a_wait_needs_blink: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && next_wait_q != '0) |-> (blink_vec != '0))
		else $error("pending wait reported with no LED blinking");

endmodule
